// ===== rtl/circular_deque_macros.svh =====
// assertion macros for the circular deque
// expects clk and arst_n in the scope of each use
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication, off while in reset
`define CDQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("circular_deque assertion failed");

// next-cycle implication, off while in reset
`define CDQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("circular_deque assertion failed");

`endif

// ===== rtl/cdq_pkg.sv =====
// shared types and codes for the circular deque
// no dependencies
`default_nettype none

package cdq_pkg;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 4;

	typedef enum logic [1:0] {
		ACT_PUSH_REAR  = 2'd0,
		ACT_PUSH_FRONT = 2'd1,
		ACT_POP_REAR   = 2'd2,
		ACT_POP_FRONT  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]               action;
		logic signed [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [COUNT_W-1:0]       entry_count;
		logic signed [WORD_W-1:0] front_word;
		logic signed [WORD_W-1:0] rear_word;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/circular_deque.sv =====
// circular deque top level: ring store in a synchronous memory, index and count control
// depends on cdq_pkg and circular_deque_macros.svh
//
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  cdq_pkg::req_t
// rsp       out        rsp_valid / rsp_stall  cdq_pkg::rsp_t
// cfg       in         cfg_wr_en              cfg_wr_data (active_capacity)
//
// an item goes from accept to its result in the output register through these steps:
// accept and store write, memory read of head and tail, result load.
// one item is in flight at a time, as the read of the ring memory is registered.
// the next item is accepted once the result is loaded, even while rsp is stalled.
// a stalled result holds; a fresh result waits in the load state until the register frees.
// reset clears indices, count and control only; the store has no clearing pass.
`default_nettype none

`include "circular_deque_macros.svh"

module circular_deque #(
	parameter int DEPTH = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire cdq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output cdq_pkg::rsp_t      rsp,
	input  wire logic          cfg_wr_en,
	input  wire logic [3:0]    cfg_wr_data
);

	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PTR_W     = (IDX_W < 4) ? IDX_W : 4;
	localparam int CAP_MAX_I = (DEPTH < 15) ? DEPTH : 15;
	localparam logic [3:0] CAP_MAX = 4'(CAP_MAX_I);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_LOAD = 3'b100
	} state_t;

	state_t                      state_q;
	logic [3:0]                  cap_cfg_q;
	logic [PTR_W-1:0]            head_q, tail_q;
	logic [cdq_pkg::COUNT_W-1:0] count_q;
	logic [1:0]                  status_q;
	logic [cdq_pkg::WORD_W-1:0]  front_rd_q, rear_rd_q;
	logic                        rsp_valid_q;
	cdq_pkg::rsp_t               rsp_q;

	logic [cdq_pkg::WORD_W-1:0]  mem [DEPTH];

	logic [3:0]                  eff_cap;
	logic [PTR_W-1:0]            cap_m1;
	logic                        accept;
	logic                        load;
	logic [PTR_W-1:0]            head_d, tail_d;
	logic [cdq_pkg::COUNT_W-1:0] count_d;
	logic [1:0]                  status_d;
	logic                        wr_en;
	logic [PTR_W-1:0]            wr_ptr;
	logic                        is_push;
	logic                        empty_now;

	// zero acts as one, above the store depth acts as the depth
	always_comb begin
		if (cap_cfg_q == 4'd0) begin
			eff_cap = 4'd1;
		end else if (cap_cfg_q > CAP_MAX) begin
			eff_cap = CAP_MAX;
		end else begin
			eff_cap = cap_cfg_q;
		end
	end
	assign cap_m1 = PTR_W'(eff_cap - 4'd1);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign load      = (state_q == S_LOAD) && (!rsp_valid_q || !rsp_stall);
	assign is_push   = (req.action == cdq_pkg::ACT_PUSH_REAR) ||
	                   (req.action == cdq_pkg::ACT_PUSH_FRONT);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = cdq_pkg::ST_DONE;
		wr_en    = 1'b0;
		wr_ptr   = tail_q;
		if (is_push) begin
			if (count_q >= eff_cap) begin
				status_d = cdq_pkg::ST_OVERFLOW;
			end else begin
				wr_en   = 1'b1;
				count_d = count_q + 1'b1;
				if (count_q == '0) begin
					head_d = '0;
					tail_d = '0;
					wr_ptr = '0;
				end else if (req.action == cdq_pkg::ACT_PUSH_REAR) begin
					tail_d = (tail_q >= cap_m1) ? '0 : tail_q + 1'b1;
					wr_ptr = tail_d;
				end else begin
					head_d = (head_q == '0) ? cap_m1 : head_q - 1'b1;
					wr_ptr = head_d;
				end
			end
		end else begin
			if (count_q == '0) begin
				status_d = cdq_pkg::ST_UNDERFLOW;
			end else begin
				count_d = count_q - 1'b1;
				case (req.action)
					cdq_pkg::ACT_POP_REAR: begin
						tail_d = (tail_q == '0) ? cap_m1 : tail_q - 1'b1;
					end
					default: begin
						head_d = (head_q >= cap_m1) ? '0 : head_q + 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cap_cfg_q <= 4'd8;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_cfg_q <= cfg_wr_data;
				head_q    <= '0;
				tail_q    <= '0;
				count_q   <= '0;
			end else if (accept) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) status_q <= status_d;
	end

	// ring store: one write port, head and tail read after the indices settle
	always_ff @(posedge clk) begin
		if (accept && wr_en) mem[IDX_W'(wr_ptr)] <= req.push_value;
		if (state_q == S_READ) begin
			front_rd_q <= mem[IDX_W'(head_q)];
			rear_rd_q  <= mem[IDX_W'(tail_q)];
		end
	end

	assign empty_now = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.status      <= status_q;
			rsp_q.entry_count <= count_q;
			rsp_q.front_word  <= empty_now ? '0 : $signed(front_rd_q);
			rsp_q.rear_word   <= empty_now ? '0 : $signed(rear_rd_q);
			rsp_q.is_empty    <= empty_now;
			rsp_q.is_full     <= (count_q == eff_cap);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`CDQ_ASSERT_IMPL(a_count_le_cap, 1'b1, count_q <= eff_cap)
	`CDQ_ASSERT_IMPL(a_ptrs_in_ring, 1'b1, (head_q <= cap_m1) && (tail_q <= cap_m1))
	`CDQ_ASSERT_IMPL(a_empty_zero_words, rsp_valid_q && rsp_q.is_empty,
		(rsp_q.front_word == '0) && (rsp_q.rear_word == '0))
	`CDQ_ASSERT_IMPL(a_overflow_full, rsp_valid_q && (rsp_q.status == cdq_pkg::ST_OVERFLOW),
		rsp_q.is_full)
	`CDQ_ASSERT_NEXT(a_push_counts, accept && is_push && (count_q < eff_cap),
		count_q == 4'($past(count_q) + 4'd1))

endmodule

`default_nettype wire
